// ----- hw/rtl/riff_wave_header_parser_macros.svh -----
// Assertion macros used by the checker of the RIFF/WAVE header parser.
// No dependencies; expects a clock i_clk and reset i_rst_n in scope.
`ifndef RIFF_WAVE_HEADER_PARSER_MACROS_SVH
`define RIFF_WAVE_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define RWH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RWH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/rwhp_pkg.sv -----
// Package of the RIFF/WAVE header parser: tags, phase and status codes,
// and the command/status structs between controller and datapath. No dependencies.
package rwhp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam int unsigned MS_PER_SEC = 1000;
    localparam int unsigned FMT_BYTES  = 16;
    localparam int unsigned QUOT_W     = 42;   // data_len*1000 fits in 42 bits

    // configuration register indexes
    localparam logic CFG_EXPECTED_SIZE = 1'b0;
    localparam logic CFG_CHECK_ENABLE  = 1'b1;

    typedef enum logic [3:0] {
        PH_RIFF = 4'd0,
        PH_RLEN = 4'd1,
        PH_WAVE = 4'd2,
        PH_CTAG = 4'd3,
        PH_CLEN = 4'd4,
        PH_BODY = 4'd5,
        PH_DATA = 4'd6,
        PH_PAD  = 4'd7,
        PH_IDLE = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOT_RIFF = 3'd1,
        ST_NOT_WAVE = 3'd2,
        ST_NO_DATA  = 3'd3,
        ST_SIZE     = 3'd4,
        ST_ZERO_RATE = 3'd5,
        ST_TRUNC    = 3'd6
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    shift;      // header byte into the word assembler
        logic    dec_riff;
        logic    load_rlen;
        logic    load_tag;
        logic    load_clen;
        logic    body;       // skipped/captured chunk body byte
        logic    data_dec;
        logic    clr_pad;
        logic    emit_pay;
        logic    emit_sum;
        t_status sum_status;
        logic    use_byte;   // summary carries the current byte
        logic    do_div;     // summary needs the duration division
        logic    restart;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic accept;
        logic last;
        logic word_full;
        logic is_riff;
        logic is_wave;
        logic tag_data;
        logic w_zero;
        logic mismatch;
        logic riff_zero;
        logic riff_end;    // walk bound reaches zero with this byte
        logic chunk_one;
        logic pad;
        logic rate_zero;
    } t_stat;

endpackage

// ----- hw/rtl/rwhp_ctrl.sv -----
// Parse controller of the RIFF/WAVE header parser: phase state machine that
// turns datapath status into commands. Depends on rwhp_pkg.
module rwhp_ctrl
    import rwhp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_phase r_phase, n_phase;
    t_cmd   c;

    function automatic t_cmd f_fin(t_cmd ci, t_status s, logic ub, logic dv, logic lst);
        t_cmd co;
        co            = ci;
        co.emit_sum   = 1'b1;
        co.sum_status = s;
        co.use_byte   = ub;
        co.do_div     = dv;
        co.restart    = lst;
        return co;
    endfunction

    function automatic t_cmd f_fin_data(t_cmd ci, t_stat st, logic ub);
        if (st.rate_zero) return f_fin(ci, ST_ZERO_RATE, ub, 1'b0, st.last);
        return f_fin(ci, ST_OK, ub, 1'b1, st.last);
    endfunction

    // chunk boundary: end of walk, truncation on the last byte, or wait for next tag
    function automatic t_cmd f_boundary(t_cmd ci, t_stat st);
        if (st.riff_end) return f_fin(ci, ST_NO_DATA, 1'b0, 1'b0, st.last);
        if (st.last) return f_fin(ci, ST_TRUNC, 1'b0, 1'b0, 1'b1);
        return ci;
    endfunction

    function automatic t_cmd f_trunc(t_cmd ci, t_stat st, logic ub);
        if (st.last) return f_fin(ci, ST_TRUNC, ub, 1'b0, 1'b1);
        return ci;
    endfunction

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_phase <= PH_RIFF;
        else          r_phase <= n_phase;
    end

    // command outputs
    always_comb begin
        c = '0;
        if (i_stat.accept) begin
            case (r_phase)
                PH_RIFF, PH_RLEN, PH_WAVE, PH_CTAG, PH_CLEN: begin
                    c.shift    = 1'b1;
                    c.dec_riff = (r_phase == PH_CTAG) || (r_phase == PH_CLEN);
                    if (!i_stat.word_full) begin
                        c = f_trunc(c, i_stat, 1'b0);
                    end else if (r_phase == PH_RIFF) begin
                        if (!i_stat.is_riff) c = f_fin(c, ST_NOT_RIFF, 1'b0, 1'b0, i_stat.last);
                        else                 c = f_trunc(c, i_stat, 1'b0);
                    end else if (r_phase == PH_RLEN) begin
                        c.load_rlen = 1'b1;
                        c = f_trunc(c, i_stat, 1'b0);
                    end else if (r_phase == PH_WAVE) begin
                        if (!i_stat.is_wave)
                            c = f_fin(c, ST_NOT_WAVE, 1'b0, 1'b0, i_stat.last);
                        else if (i_stat.riff_zero)
                            c = f_fin(c, ST_NO_DATA, 1'b0, 1'b0, i_stat.last);
                        else
                            c = f_trunc(c, i_stat, 1'b0);
                    end else if (r_phase == PH_CTAG) begin
                        c.load_tag = 1'b1;
                        c = f_trunc(c, i_stat, 1'b0);
                    end else begin
                        c.load_clen = 1'b1;
                        if (i_stat.tag_data) begin
                            if (i_stat.mismatch)
                                c = f_fin(c, ST_SIZE, 1'b0, 1'b0, i_stat.last);
                            else if (i_stat.w_zero)
                                c = f_fin_data(c, i_stat, 1'b0);
                            else
                                c = f_trunc(c, i_stat, 1'b0);
                        end else if (i_stat.w_zero) begin
                            c = f_boundary(c, i_stat);
                        end else begin
                            c = f_trunc(c, i_stat, 1'b0);
                        end
                    end
                end
                PH_BODY: begin
                    c.dec_riff = 1'b1;
                    c.body     = 1'b1;
                    if (i_stat.chunk_one && !i_stat.pad) c = f_boundary(c, i_stat);
                    else                                 c = f_trunc(c, i_stat, 1'b0);
                end
                PH_DATA: begin
                    c.dec_riff = 1'b1;
                    c.data_dec = 1'b1;
                    if (i_stat.chunk_one)  c = f_fin_data(c, i_stat, 1'b1);
                    else if (i_stat.last)  c = f_fin(c, ST_TRUNC, 1'b1, 1'b0, 1'b1);
                    else                   c.emit_pay = 1'b1;
                end
                PH_PAD: begin
                    c.dec_riff = 1'b1;
                    c.clr_pad  = 1'b1;
                    c = f_boundary(c, i_stat);
                end
                default: begin
                    c.restart = i_stat.last;
                end
            endcase
        end
        o_cmd = c;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (c.restart) begin
            n_phase = PH_RIFF;
        end else if (c.emit_sum) begin
            n_phase = PH_IDLE;
        end else if (i_stat.accept) begin
            case (r_phase)
                PH_RIFF: if (i_stat.word_full) n_phase = PH_RLEN;
                PH_RLEN: if (i_stat.word_full) n_phase = PH_WAVE;
                PH_WAVE: if (i_stat.word_full) n_phase = PH_CTAG;
                PH_CTAG: if (i_stat.word_full) n_phase = PH_CLEN;
                PH_CLEN: begin
                    if (i_stat.word_full) begin
                        if (i_stat.tag_data)    n_phase = PH_DATA;
                        else if (i_stat.w_zero) n_phase = PH_CTAG;
                        else                    n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (i_stat.chunk_one) n_phase = i_stat.pad ? PH_PAD : PH_CTAG;
                end
                PH_DATA: n_phase = PH_DATA;
                PH_PAD:  n_phase = PH_CTAG;
                default: n_phase = PH_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/rwhp_datapath.sv -----
// Datapath of the RIFF/WAVE header parser: word assembler, chunk counters,
// fmt capture, config registers, duration divider and output register. Uses rwhp_pkg.
module rwhp_datapath
    import rwhp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  logic [7:0]    i_byte,
    input  logic          i_last,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output logic [223:0]  o_m_tdata,
    output logic          o_m_tuser,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  t_cmd          i_cmd,
    output t_stat         o_stat
);

    localparam int unsigned OFF_W = $clog2(FMT_BYTES) + 1;
    localparam int unsigned CNT_W = $clog2(QUOT_W + 1);

    // parse state
    logic [31:0] r_word;
    logic [1:0]  r_fbc;
    logic [31:0] r_tag, r_riff, r_chunk;
    logic        r_pad;
    logic [OFF_W-1:0] r_off;
    logic [7:0]  r_fmt [FMT_BYTES];
    logic [7:0]  n_fmt [FMT_BYTES];
    logic [15:0] r_fmt_len, n_fmt_len;
    logic [31:0] r_data_len, n_data_len;
    logic [31:0] r_exp;
    logic        r_chk_en;

    // output register
    logic        r_out_valid, r_kind;
    logic [7:0]  r_pbyte;
    t_status     r_status;
    logic [15:0] r_ftag, r_chan, r_balign, r_bits, r_flen;
    logic [31:0] r_srate, r_avg, r_dlen, r_dur;

    // divider
    logic              r_busy;
    logic [QUOT_W-1:0] r_dq, n_dq;
    logic [31:0]       r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [32:0]       w_trial;
    logic              w_ge;

    logic [31:0] w_word, w_rate;
    logic        w_accept;
    logic [QUOT_W-1:0] w_dl, w_prod;

    assign w_word     = {i_byte, r_word[31:8]};
    assign o_s_tready = !r_busy && (!r_out_valid || i_m_tready);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next captured values, seen by the summary of this same byte
    always_comb begin
        for (int k = 0; k < FMT_BYTES; k++) n_fmt[k] = r_fmt[k];
        if (i_cmd.body && !r_off[OFF_W-1] && (r_tag == TAG_FMT))
            n_fmt[r_off[OFF_W-2:0]] = i_byte;
        n_fmt_len  = (i_cmd.load_clen && r_tag == TAG_FMT) ? w_word[15:0] : r_fmt_len;
        n_data_len = (i_cmd.load_clen && r_tag == TAG_DATA) ? w_word : r_data_len;
    end

    assign w_rate = {n_fmt[11], n_fmt[10], n_fmt[9], n_fmt[8]};

    // status toward the controller
    always_comb begin
        o_stat.accept    = w_accept;
        o_stat.last      = i_last;
        o_stat.word_full = (r_fbc == 2'd3);
        o_stat.is_riff   = (w_word == TAG_RIFF);
        o_stat.is_wave   = (w_word == TAG_WAVE);
        o_stat.tag_data  = (r_tag == TAG_DATA);
        o_stat.w_zero    = (w_word == 32'd0);
        o_stat.mismatch  = r_chk_en && (w_word != r_exp);
        o_stat.riff_zero = (r_riff == 32'd0);
        o_stat.riff_end  = (r_riff <= 32'd1);
        o_stat.chunk_one = (r_chunk == 32'd1);
        o_stat.pad       = r_pad;
        o_stat.rate_zero = (w_rate == 32'd0);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp    <= '0;
            r_chk_en <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_EXPECTED_SIZE: r_exp    <= i_cfg_data;
                CFG_CHECK_ENABLE:  r_chk_en <= i_cfg_data[0];
                default:           r_exp    <= r_exp;
            endcase
        end
    end

    // parse registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_word     <= '0;
            r_fbc      <= '0;
            r_tag      <= '0;
            r_riff     <= '0;
            r_chunk    <= '0;
            r_pad      <= 1'b0;
            r_off      <= '0;
            r_fmt_len  <= '0;
            r_data_len <= '0;
            for (int k = 0; k < FMT_BYTES; k++) r_fmt[k] <= '0;
        end else begin
            if (i_cmd.shift) begin
                r_word <= (r_fbc == 2'd3) ? 32'd0 : w_word;
                r_fbc  <= r_fbc + 2'd1;
            end
            if (i_cmd.load_rlen)
                r_riff <= w_word - 32'd4;
            else if (i_cmd.dec_riff && r_riff != 32'd0)
                r_riff <= r_riff - 32'd1;
            if (i_cmd.load_tag) r_tag <= w_word;
            if (i_cmd.load_clen) begin
                r_chunk <= w_word;
                r_pad   <= w_word[0];
                r_off   <= '0;
            end else begin
                if (i_cmd.body || i_cmd.data_dec) r_chunk <= r_chunk - 32'd1;
                if (i_cmd.clr_pad) r_pad <= 1'b0;
                if (i_cmd.body && !r_off[OFF_W-1]) r_off <= r_off + 1'b1;
            end
            for (int k = 0; k < FMT_BYTES; k++) r_fmt[k] <= n_fmt[k];
            r_fmt_len  <= n_fmt_len;
            r_data_len <= n_data_len;
        end
    end

    // data_len * 1000 as shifts: x*1024 - x*16 - x*8
    assign w_dl   = {{(QUOT_W-32){1'b0}}, n_data_len};
    assign w_prod = (w_dl << 10) - (w_dl << 4) - (w_dl << 3);

    // restoring divider step, one quotient bit per cycle
    assign w_trial = {r_rem, r_dq[QUOT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_avg});
    assign n_dq    = {r_dq[QUOT_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.emit_sum && i_cmd.do_div) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sum && i_cmd.do_div) begin
            r_dq  <= w_prod;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= n_dq;
            r_rem <= w_ge ? 32'(w_trial - {1'b0, r_avg}) : w_trial[31:0];
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;
            if (i_cmd.emit_pay || (i_cmd.emit_sum && !i_cmd.do_div)) r_out_valid <= 1'b1;
            if (r_busy && r_cnt == CNT_W'(1)) r_out_valid <= 1'b1;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_pay) begin
            r_kind   <= 1'b0;
            r_pbyte  <= i_byte;
            r_status <= ST_OK;
            r_ftag   <= '0;
            r_chan   <= '0;
            r_srate  <= '0;
            r_avg    <= '0;
            r_balign <= '0;
            r_bits   <= '0;
            r_flen   <= '0;
            r_dlen   <= '0;
            r_dur    <= '0;
        end else if (i_cmd.emit_sum) begin
            r_kind   <= 1'b1;
            r_pbyte  <= i_cmd.use_byte ? i_byte : 8'd0;
            r_status <= i_cmd.sum_status;
            r_ftag   <= {n_fmt[1], n_fmt[0]};
            r_chan   <= {n_fmt[3], n_fmt[2]};
            r_srate  <= {n_fmt[7], n_fmt[6], n_fmt[5], n_fmt[4]};
            r_avg    <= w_rate;
            r_balign <= {n_fmt[13], n_fmt[12]};
            r_bits   <= {n_fmt[15], n_fmt[14]};
            r_flen   <= n_fmt_len;
            r_dlen   <= n_data_len;
            r_dur    <= '0;
        end else if (r_busy && r_cnt == CNT_W'(1)) begin
            // saturate a quotient above 32 bits
            r_dur <= (|n_dq[QUOT_W-1:32]) ? 32'hFFFF_FFFF : n_dq[31:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_kind;
    assign o_m_tdata  = {5'd0, r_dur, r_dlen, r_flen, r_bits, r_balign, r_avg, r_srate,
                         r_chan, r_ftag, r_status, r_pbyte};

endmodule

// ----- hw/rtl/riff_wave_header_parser.sv -----
// Top level of the RIFF/WAVE header parser: parse controller plus datapath.
// Depends on rwhp_pkg, rwhp_ctrl and rwhp_datapath.
//
//  channel  | direction | handshake               | content
//  s_axis   | in        | i_s_tvalid/o_s_tready   | tdata byte_in, tlast last_byte
//  m_axis   | out       | o_m_tvalid/i_m_tready   | tdata summary/payload, tuser out_kind
//  cfg      | in        | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One input byte per cycle while the divider is idle and the output register is free or being drained.
// A summary with status ok goes through the restoring divider
// (one quotient bit per cycle); input is held off until it is done.
// Synchronous active-low reset returns to the RIFF tag search, no clearing pass.
// A stalled output holds its transaction and back-pressures the input.
module riff_wave_header_parser
    import rwhp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] byte_in
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [7:0] payload_byte, [10:8] status, [26:11] format_tag, [42:27] channels,
    // [74:43] sample_rate, [106:75] avg_bytes_per_sec, [122:107] block_align,
    // [138:123] bits_per_sample, [154:139] format_length, [186:155] data_length,
    // [218:187] duration_ms, [223:219] zero
    output logic [223:0] o_m_tdata,
    output logic         o_m_tuser,   // [0] out_kind
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign o_cfg_ready = 1'b1;

    rwhp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rwhp_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

// ----- hw/rtl/rwhp_checker.sv -----
// Port-level checker of the RIFF/WAVE header parser, bound to the top level.
// Depends on riff_wave_header_parser_macros.svh.
`include "riff_wave_header_parser_macros.svh"

module rwhp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [223:0] o_m_tdata,
    input logic         o_m_tuser
);

    // a stalled result transaction holds
    `RWH_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "output changed while stalled")
    // no byte taken while a result is stuck
    `RWH_ASSERT_NOW(a_backpressure, o_m_tvalid && !i_m_tready, !o_s_tready, "input taken with output stalled")
    // payload transactions carry status ok
    `RWH_ASSERT_NOW(a_pay_status, o_m_tvalid && !o_m_tuser, o_m_tdata[10:8] == 3'd0, "payload with status")
    // summary status code in range
    `RWH_ASSERT_NOW(a_sum_status, o_m_tvalid && o_m_tuser, o_m_tdata[10:8] != 3'd7, "bad summary status")

endmodule

bind riff_wave_header_parser rwhp_checker u_rwhp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ----- tb/tb_riff_wave_header_parser.sv -----
// Self-checking testbench of riff_wave_header_parser: builds WAV byte streams,
// predicts every payload and summary transaction and compares them field by field.
// Depends on rwhp_pkg and the riff_wave_header_parser RTL.
module tb_riff_wave_header_parser;
    import rwhp_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 64;    // covers the divider run
    localparam int unsigned TARGET_BYTES = 1100;
    localparam int unsigned MIN_PHASES   = 4;     // one of each idling mode
    localparam logic [31:0] TAG_FACT     = 32'h7463_6166;

    typedef logic [7:0] byte_q_t[$];

    typedef struct {
        logic        kind;
        logic [7:0]  pay;
        logic [2:0]  status;
        logic [15:0] ftag;
        logic [15:0] chans;
        logic [31:0] srate;
        logic [31:0] brate;
        logic [15:0] balign;
        logic [15:0] bits;
        logic [15:0] flen;
        logic [31:0] dlen;
        logic [31:0] dur;
    } wav_result_t;

    // one file to build
    typedef struct {
        bit          bad_riff;
        bit          bad_wave;
        longint      riff_len;    // -1: consistent with the chunks
        int          short_fmt;   // -1: none, else length of an early short fmt chunk
        int          fmt_len;     // -1: no fmt chunk
        logic [7:0]  fmt[16];
        int          fact_len;    // -1: none
        int          junk_len;    // -1: none
        bit          has_data;
        logic [31:0] data_len;
        int          data_sent;
        int          cut;         // 0: whole file
        int          tail;        // noise bytes after a complete file
    } wav_spec_t;

    typedef enum {
        SC_BAD_RIFF, SC_BAD_WAVE, SC_RIFF_LEN4, SC_EMPTY_DATA, SC_MISMATCH,
        SC_ZERO_RATE, SC_TRUNC, SC_NO_DATA, SC_SHORT_FMT, SC_WRAP_LEN, SC_FMT_ONES
    } scen_t;

    typedef struct {
        scen_t sc;
        int    status;   // -1: left to the predictor
    } dir_row_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [7:0]   i_s_tdata;
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [223:0] o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_index;
    logic [31:0]  i_cfg_data;

    riff_wave_header_parser DUT (.*);

    // stream waiting to be sent, expected transactions, typed summary codes
    logic [7:0]  send_byte_q[$];
    logic        send_last_q[$];
    wav_result_t expected_q[$];
    int          typed_status_q[$];

    int unsigned src_idle_pct;
    int unsigned snk_stall_pct;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned bytes_queued;

    // predictor state
    logic [31:0] cfg_expected;
    logic        cfg_check_en;
    t_phase      ph;
    logic [1:0]  fld_cnt;
    logic [31:0] word_sr;
    logic [31:0] cur_tag;
    logic [31:0] riff_rem;
    logic [31:0] chunk_rem;
    logic        pad_pend;
    logic [7:0]  fmt_cap[16];
    logic [15:0] fmt_len_q;
    logic [31:0] data_len_q;

    always begin
        i_clk = 1'b0; #5;
        i_clk = 1'b1; #5;
    end

    // one line per mismatch, counted
    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
        err_cnt++;
    endtask

    //--------------------------------------------------------------------
    // predictor
    //--------------------------------------------------------------------
    function automatic logic [15:0] cap16(int i);
        return {fmt_cap[i + 1], fmt_cap[i]};
    endfunction

    function automatic logic [31:0] cap32(int i);
        return {cap16(i + 2), cap16(i)};
    endfunction

    task automatic start_file();
        ph         = PH_RIFF;
        fld_cnt    = '0;
        word_sr    = '0;
        cur_tag    = '0;
        riff_rem   = '0;
        chunk_rem  = '0;
        pad_pend   = 1'b0;
        fmt_len_q  = '0;
        data_len_q = '0;
        foreach (fmt_cap[i]) fmt_cap[i] = '0;
    endtask

    task automatic emit_summary(t_status st, logic [7:0] pb, logic [31:0] dur, bit last);
        wav_result_t r;
        int          typed;
        r.kind = 1'b1;   r.pay = pb;          r.status = st;
        r.ftag = cap16(0); r.chans = cap16(2); r.srate = cap32(4);
        r.brate = cap32(8); r.balign = cap16(12); r.bits = cap16(14);
        r.flen = fmt_len_q; r.dlen = data_len_q; r.dur = dur;
        expected_q.push_back(r);
        if (typed_status_q.size() != 0) begin
            typed = typed_status_q.pop_front();
            if (typed >= 0 && typed != int'(st))
                report("typed status", 32'(st), 32'(typed));
        end
        if (last) start_file();
        else ph = PH_IDLE;
    endtask

    task automatic finish_data(logic [7:0] pb, bit last);
        logic [31:0] rate;
        logic [63:0] quot;
        rate = cap32(8);
        if (rate == 0) begin
            emit_summary(ST_ZERO_RATE, pb, '0, last);
        end else begin
            quot = (64'(data_len_q) * MS_PER_SEC) / rate;
            if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
            emit_summary(ST_OK, pb, quot[31:0], last);
        end
    endtask

    task automatic chunk_boundary(bit last);
        if (riff_rem == 0) begin
            emit_summary(ST_NO_DATA, '0, '0, last);
        end else begin
            ph = PH_CTAG;
            fld_cnt = '0;
            word_sr = '0;
            if (last) emit_summary(ST_TRUNC, '0, '0, 1);
        end
    endtask

    task automatic end_of_body(bit last);
        if (pad_pend) begin
            ph = PH_PAD;
            if (last) emit_summary(ST_TRUNC, '0, '0, 1);
        end else begin
            chunk_boundary(last);
        end
    endtask

    task automatic dec_riff();
        if (riff_rem != 0) riff_rem--;
    endtask

    // one accepted stream byte
    task automatic wav_step(logic [7:0] b, bit last);
        logic [31:0] w;
        wav_result_t r;
        case (ph)
            PH_RIFF, PH_RLEN, PH_WAVE, PH_CTAG, PH_CLEN: begin
                word_sr = {b, word_sr[31:8]};
                if (ph >= PH_CTAG) dec_riff();
                fld_cnt = fld_cnt + 2'd1;
                if (fld_cnt == 0) begin
                    w = word_sr;
                    word_sr = '0;
                    case (ph)
                        PH_RIFF: begin
                            if (w != TAG_RIFF) begin
                                emit_summary(ST_NOT_RIFF, '0, '0, last);
                                return;
                            end
                            ph = PH_RLEN;
                        end
                        PH_RLEN: begin
                            riff_rem = w - 32'd4;
                            ph = PH_WAVE;
                        end
                        PH_WAVE: begin
                            if (w != TAG_WAVE) begin
                                emit_summary(ST_NOT_WAVE, '0, '0, last);
                                return;
                            end
                            if (riff_rem == 0) begin
                                emit_summary(ST_NO_DATA, '0, '0, last);
                                return;
                            end
                            ph = PH_CTAG;
                        end
                        PH_CTAG: begin
                            cur_tag = w;
                            ph = PH_CLEN;
                        end
                        default: begin
                            chunk_rem = w;
                            pad_pend = w[0];
                            if (cur_tag == TAG_DATA) begin
                                data_len_q = w;
                                if (cfg_check_en && w != cfg_expected) begin
                                    emit_summary(ST_SIZE, '0, '0, last);
                                    return;
                                end
                                if (w == 0) begin
                                    finish_data('0, last);
                                    return;
                                end
                                ph = PH_DATA;
                            end else begin
                                if (cur_tag == TAG_FMT) fmt_len_q = w[15:0];
                                if (w == 0) begin
                                    end_of_body(last);
                                    return;
                                end
                                ph = PH_BODY;
                            end
                        end
                    endcase
                end
            end
            PH_BODY: begin
                dec_riff();
                if (word_sr < FMT_BYTES) begin
                    if (cur_tag == TAG_FMT) fmt_cap[word_sr] = b;
                    word_sr++;
                end
                chunk_rem--;
                if (chunk_rem == 0) begin
                    end_of_body(last);
                    return;
                end
            end
            PH_DATA: begin
                dec_riff();
                chunk_rem--;
                if (chunk_rem == 0) begin
                    finish_data(b, last);
                end else if (last) begin
                    emit_summary(ST_TRUNC, b, '0, 1);
                end else begin
                    r = '{default: '0};
                    r.pay = b;
                    expected_q.push_back(r);
                end
                return;
            end
            PH_PAD: begin
                dec_riff();
                pad_pend = 1'b0;
                chunk_boundary(last);
                return;
            end
            default: begin
                if (last) start_file();
                return;
            end
        endcase
        if (last) emit_summary(ST_TRUNC, '0, '0, 1);
    endtask

    //--------------------------------------------------------------------
    // checking
    //--------------------------------------------------------------------
    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report(what, got, want);
    endtask

    task automatic check_result();
        wav_result_t e;
        if (expected_q.size() == 0) begin
            report("unexpected transaction", o_m_tdata[31:0], '0);
            return;
        end
        e = expected_q.pop_front();
        check_field("out_kind",        32'(o_m_tuser),          32'(e.kind));
        check_field("payload_byte",    32'(o_m_tdata[7:0]),     32'(e.pay));
        check_field("status",          32'(o_m_tdata[10:8]),    32'(e.status));
        check_field("format_tag",      32'(o_m_tdata[26:11]),   32'(e.ftag));
        check_field("channels",        32'(o_m_tdata[42:27]),   32'(e.chans));
        check_field("sample_rate",     o_m_tdata[74:43],        e.srate);
        check_field("avg_bytes_per_sec", o_m_tdata[106:75],     e.brate);
        check_field("block_align",     32'(o_m_tdata[122:107]), 32'(e.balign));
        check_field("bits_per_sample", 32'(o_m_tdata[138:123]), 32'(e.bits));
        check_field("format_length",   32'(o_m_tdata[154:139]), 32'(e.flen));
        check_field("data_length",     o_m_tdata[186:155],      e.dlen);
        check_field("duration_ms",     o_m_tdata[218:187],      e.dur);
        check_field("tdata pad",       32'(o_m_tdata[223:219]), '0);
    endtask

    //--------------------------------------------------------------------
    // stream driver, predictor hook and result monitor
    //--------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_m_tready <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready)
                wav_step(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready)
                check_result();
            if (!i_s_tvalid || o_s_tready) begin
                if (send_byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= send_byte_q.pop_front();
                    i_s_tlast  <= send_last_q.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // stimulus helpers
    //--------------------------------------------------------------------
    function automatic void push32(ref byte_q_t q, input logic [31:0] w);
        for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
    endfunction

    function automatic void add_chunk(ref byte_q_t q, input logic [31:0] tag,
                                      input logic [31:0] len, input int nsend,
                                      input bit use_fmt, input logic [7:0] fmt[16]);
        push32(q, tag);
        push32(q, len);
        for (int i = 0; i < nsend; i++)
            q.push_back((use_fmt && i < 16) ? fmt[i] : 8'($urandom));
        if (nsend == len && len[0]) q.push_back(8'($urandom));
    endfunction

    function automatic wav_spec_t good_spec(logic [31:0] dlen);
        wav_spec_t s;
        s.bad_riff = 0;  s.bad_wave = 0;  s.riff_len = -1;
        s.short_fmt = -1; s.fmt_len = 16; s.fact_len = -1; s.junk_len = -1;
        s.has_data = 1;  s.data_len = dlen; s.data_sent = dlen; s.cut = 0; s.tail = 0;
        foreach (s.fmt[i]) s.fmt[i] = 8'($urandom);
        // a small byte rate gives a nonzero duration
        if ($urandom_range(1)) s.fmt[8 +: 4] = '{8'($urandom_range(1, 255)), 8'd0, 8'd0, 8'd0};
        return s;
    endfunction

    task automatic queue_file(wav_spec_t s, int typed);
        byte_q_t ck, f;
        logic [31:0] rlen;
        if (s.short_fmt >= 0)
            add_chunk(ck, TAG_FMT, 32'(s.short_fmt), s.short_fmt, 1'b0, s.fmt);
        if (s.fmt_len >= 0)
            add_chunk(ck, TAG_FMT, 32'(s.fmt_len), s.fmt_len, 1'b1, s.fmt);
        if (s.fact_len >= 0)
            add_chunk(ck, TAG_FACT, 32'(s.fact_len), s.fact_len, 1'b0, s.fmt);
        if (s.junk_len >= 0)
            add_chunk(ck, $urandom, 32'(s.junk_len), s.junk_len, 1'b0, s.fmt);
        if (s.has_data) add_chunk(ck, TAG_DATA, s.data_len, s.data_sent, 1'b0, s.fmt);
        rlen = (s.riff_len >= 0) ? 32'(s.riff_len) : 32'(ck.size() + 4);
        push32(f, s.bad_riff ? TAG_RIFF ^ (32'd1 << $urandom_range(31)) : TAG_RIFF);
        push32(f, rlen);
        push32(f, s.bad_wave ? TAG_WAVE ^ (32'd1 << $urandom_range(31)) : TAG_WAVE);
        f = {f, ck};
        if (s.cut > 0 && s.cut < f.size()) f = f[0:s.cut - 1];
        repeat (s.tail) f.push_back(8'($urandom));
        foreach (f[i]) begin
            send_byte_q.push_back(f[i]);
            send_last_q.push_back(i == f.size() - 1);
        end
        bytes_queued += f.size();
        typed_status_q.push_back(typed);
    endtask

    // one register write, then valid is dropped again on the channel
    task automatic write_cfg(logic idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_EXPECTED_SIZE) cfg_expected = val;
        else cfg_check_en = val[0];
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (send_byte_q.size() != 0 || i_s_tvalid || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // directed files under the reset configuration (expected size 0, check on)
    dir_row_t dir_rows[] = '{
        '{SC_BAD_RIFF,   ST_NOT_RIFF},
        '{SC_BAD_WAVE,   ST_NOT_WAVE},
        '{SC_RIFF_LEN4,  ST_NO_DATA},
        '{SC_EMPTY_DATA, ST_OK},
        '{SC_MISMATCH,   ST_SIZE},
        '{SC_ZERO_RATE,  ST_ZERO_RATE},
        '{SC_TRUNC,      ST_TRUNC},
        '{SC_NO_DATA,    ST_NO_DATA},
        '{SC_SHORT_FMT,  -1},
        '{SC_WRAP_LEN,   -1},
        '{SC_FMT_ONES,   ST_OK}
    };

    initial begin
        wav_spec_t   s;
        int unsigned mode;
        int unsigned pick;
        logic [31:0] dlen;
        i_rst_n = 1'b0;     i_s_tvalid = 1'b0;  i_s_tdata = '0;   i_s_tlast = 1'b0;
        i_m_tready = 1'b0;  i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        cycle_cnt = 0;      err_cnt = 0;        bytes_queued = 0;
        src_idle_pct = 0;   snk_stall_pct = 0;
        cfg_expected = '0;  cfg_check_en = 1'b1;
        start_file();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (dir_rows[r]) begin
            s = good_spec(32'd0);
            case (dir_rows[r].sc)
                SC_BAD_RIFF:   s.bad_riff = 1;
                SC_BAD_WAVE:   s.bad_wave = 1;
                SC_RIFF_LEN4:  s.riff_len = 4;
                SC_EMPTY_DATA: s.fmt[8] = 8'd1;
                SC_MISMATCH:   begin s.data_len = 5; s.data_sent = 5; end
                SC_ZERO_RATE:  s.fmt[8 +: 4] = '{8'd0, 8'd0, 8'd0, 8'd0};
                SC_TRUNC:      begin s.data_len = 0; s.data_sent = 0; s.cut = 30; end
                SC_NO_DATA:    begin s.has_data = 0; s.junk_len = 3; end
                SC_SHORT_FMT:  begin s.short_fmt = 6; s.fact_len = 4; end
                SC_WRAP_LEN:   s.riff_len = 0;
                SC_FMT_ONES:   begin s.fmt = '{default: 8'hFF}; s.fmt_len = 17; end
                default: ;
            endcase
            queue_file(s, dir_rows[r].status);
        end
        drain();

        // random phases: new settings, new idling mode, a handful of files each
        for (int p = 0; p < MIN_PHASES || bytes_queued < TARGET_BYTES; p++) begin
            mode = p % 4;
            src_idle_pct  = (mode == 1 || mode == 3) ? ((mode == 1) ? 53 : 22) : 0;
            snk_stall_pct = (mode == 2 || mode == 3) ? ((mode == 2) ? 53 : 22) : 0;
            case ($urandom_range(3))
                0: write_cfg(CFG_EXPECTED_SIZE, 32'd0);
                1: write_cfg(CFG_EXPECTED_SIZE, 32'hFFFF_FFFF);
                2: write_cfg(CFG_EXPECTED_SIZE, $urandom);
                default: write_cfg(CFG_EXPECTED_SIZE, $urandom_range(1, 24));
            endcase
            write_cfg(CFG_CHECK_ENABLE, (p % 3 == 2) ? 32'd0 : 32'd1);
            repeat (3) begin
                dlen = (cfg_check_en && cfg_expected <= 24) ? cfg_expected
                                                            : $urandom_range(0, 24);
                s = good_spec(dlen);
                pick = $urandom_range(99);
                if (pick < 70) begin
                    // well formed, optional extra chunks
                    if ($urandom_range(3) == 0) s.fact_len = $urandom_range(0, 5);
                    if ($urandom_range(3) == 0) s.junk_len = $urandom_range(0, 7);
                    if ($urandom_range(4) == 0) s.short_fmt = $urandom_range(0, 15);
                    if ($urandom_range(4) == 0) s.fmt_len = $urandom_range(16, 21);
                    if ($urandom_range(5) == 0) s.tail = $urandom_range(1, 4);
                end else if (pick < 78) begin
                    s.cut = $urandom_range(1, 60);
                end else if (pick < 84) begin
                    // huge data length, cut short
                    s.data_len = $urandom;
                    s.data_sent = $urandom_range(0, 12);
                    s.cut = 44 + s.data_sent;
                end else if (pick < 90) begin
                    s.riff_len = $urandom_range(0, 40);
                end else if (pick < 95) begin
                    s.bad_riff = 1'($urandom_range(1));
                    s.bad_wave = !s.bad_riff;
                end else begin
                    s.fmt_len = -1;
                end
                queue_file(s, -1);
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
